@@ rtl/lsbc_pkg.sv @@
// shared types, constants and step function of the line segment clipper
package lsbc_pkg;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int DW           = COORD_BITS + 1;
    localparam int TW           = FRAC_BITS + 1;
    localparam int QW           = FRAC_BITS + 2;
    localparam int PW           = DW + TW + 1;
    localparam int LANES        = 4;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int DIV_A        = (DIV_STEPS + 2) / 3;
    localparam int DIV_C        = DIV_STEPS - 2 * DIV_A;
    localparam int CFG_IDX_BITS = 3;
    localparam int STAGES       = 7;

    localparam logic [TW-1:0] T_ONE  = TW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] T_OVER = T_ONE + TW'(1);
    localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    localparam logic [COORD_BITS-1:0] WIN_MIN_RESET = '0;
    localparam logic [COORD_BITS-1:0] WIN_MAX_RESET = {1'b0, {(COORD_BITS - 1){1'b1}}};

    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX = CFG_IDX_BITS'(3);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } seg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clip_start_x;
        logic signed [COORD_BITS-1:0] clip_start_y;
        logic signed [COORD_BITS-1:0] clip_end_x;
        logic signed [COORD_BITS-1:0] clip_end_y;
        logic                         visible;
    } clip_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [DW-1:0]         dx;
        logic signed [DW-1:0]         dy;
        logic                         bad;
    } geo_t;

    typedef struct packed {
        logic                  active;
        logic                  enter;
        logic                  big;
        logic [COORD_BITS-1:0] pm;
        logic [COORD_BITS-1:0] rem;
        logic [QW-1:0]         quo;
    } lane_t;

    typedef struct packed {
        geo_t          geo;
        logic [TW-1:0] t_in;
        logic [TW-1:0] t_out;
        logic          ok;
    } sel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [PW-1:0]         mx_in;
        logic signed [PW-1:0]         my_in;
        logic signed [PW-1:0]         mx_out;
        logic signed [PW-1:0]         my_out;
        logic                         ok;
    } mul_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [COORD_BITS:0] div_step(
        input logic [COORD_BITS-1:0] rem,
        input logic [COORD_BITS-1:0] pm
    );
        logic [COORD_BITS:0] dbl;
        logic [COORD_BITS:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, pm};
        if (dbl >= {1'b0, pm})
            return {1'b1, diff[COORD_BITS-1:0]};
        else
            return {1'b0, dbl[COORD_BITS-1:0]};
    endfunction

endpackage

@@ rtl/line_segment_window_clipper.sv @@
// top level of the pipelined line segment window clipper
//
// Segments arrive on seg (seg_valid/seg_ready) and one clipped result per
// request leaves on clip (clip_valid/clip_ready), in order. The window edges
// are written through cfg_valid/cfg_index/cfg_data; cfg_ready is always high
// and writes are meant to happen while no segment is in flight.
// From acceptance to clip_valid a segment passes one setup stage, three
// divider stages (one restoring step per quotient bit, six, six and five per stage,
// four window boundaries side by side), then select, multiply and round stages.
// Throughput is one segment per cycle while clip_ready does not stall a full pipeline.
// Every stage carries its own valid bit and holds when the stage after it is
// full and stalled, so a stalled receiver backs up the pipeline one stage at
// a time; seg_ready stays high while any bubble remains.
// Reset empties the pipeline and loads the window to x and y from 0 to 32767.
// A rejected segment comes out with visible low and all coordinates zero.
module line_segment_window_clipper (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   seg_valid,
    output logic                                   seg_ready,
    input  lsbc_pkg::seg_t                         seg,
    output logic                                   clip_valid,
    input  logic                                   clip_ready,
    output lsbc_pkg::clip_t                        clip,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lsbc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [lsbc_pkg::COORD_BITS-1:0]        cfg_data
);
    import lsbc_pkg::*;

    logic [COORD_BITS-1:0] win_x_min_reg;
    logic [COORD_BITS-1:0] win_x_max_reg;
    logic [COORD_BITS-1:0] win_y_min_reg;
    logic [COORD_BITS-1:0] win_y_max_reg;
    logic [STAGES-1:0]     valid_reg;
    logic [STAGES-1:0]     valid_next;
    logic [STAGES-1:0]     en;
    geo_t                  geo0;
    geo_t                  geo1_reg;
    geo_t                  geo2_reg;
    geo_t                  geo3_reg;
    lane_t [LANES-1:0]     lanes_edge;
    lane_t [LANES-1:0]     lanes_div;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_min_reg <= WIN_MIN_RESET;
            win_x_max_reg <= WIN_MAX_RESET;
            win_y_min_reg <= WIN_MIN_RESET;
            win_y_max_reg <= WIN_MAX_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_MIN: win_x_min_reg <= cfg_data;
                REG_X_MAX: win_x_max_reg <= cfg_data;
                REG_Y_MIN: win_y_min_reg <= cfg_data;
                REG_Y_MAX: win_y_max_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // a stage loads when it is empty or the stage after it moves on
    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || clip_ready;
        for (int k = STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
        valid_next[0] = en[0] ? seg_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign seg_ready  = en[0];
    assign clip_valid = valid_reg[STAGES-1];

    lsbc_edge u_edge (
        .clk       (clk),
        .en        (en[0]),
        .seg       (seg),
        .win_x_min (win_x_min_reg),
        .win_x_max (win_x_max_reg),
        .win_y_min (win_y_min_reg),
        .win_y_max (win_y_max_reg),
        .geo_reg   (geo0),
        .lanes_reg (lanes_edge)
    );

    for (genvar k = 0; k < LANES; k++)
    begin : g_div
        lsbc_div u_div (
            .clk      (clk),
            .en       (en[3:1]),
            .lane_in  (lanes_edge[k]),
            .lane_reg (lanes_div[k])
        );
    end

    // segment geometry rides alongside the divider stages
    always_ff @(posedge clk)
    begin
        if (en[1])
            geo1_reg <= geo0;
        if (en[2])
            geo2_reg <= geo1_reg;
        if (en[3])
            geo3_reg <= geo2_reg;
    end

    lsbc_interp u_interp (
        .clk      (clk),
        .en       (en[6:4]),
        .geo      (geo3_reg),
        .lanes    (lanes_div),
        .clip_reg (clip)
    );

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && !clip.visible |-> clip.clip_start_x == '0 &&
            clip.clip_start_y == '0 && clip.clip_end_x == '0 && clip.clip_end_y == '0)
        else $error("rejected segment carries nonzero coordinates");

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[STAGES-1] |-> seg_ready)
        else $error("input stalled while output stage is empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> valid_reg[0])
        else $error("accepted request did not enter the pipeline");

endmodule

@@ rtl/lsbc_edge.sv @@
// edge setup stage: deltas, per-edge magnitudes and classification
module lsbc_edge (
    input  logic                                 clk,
    input  logic                                 en,
    input  lsbc_pkg::seg_t                       seg,
    input  logic [lsbc_pkg::COORD_BITS-1:0]      win_x_min,
    input  logic [lsbc_pkg::COORD_BITS-1:0]      win_x_max,
    input  logic [lsbc_pkg::COORD_BITS-1:0]      win_y_min,
    input  logic [lsbc_pkg::COORD_BITS-1:0]      win_y_max,
    output lsbc_pkg::geo_t                       geo_reg,
    output lsbc_pkg::lane_t [lsbc_pkg::LANES-1:0] lanes_reg
);
    import lsbc_pkg::*;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] p [LANES];
    logic signed [DW-1:0] q [LANES];
    logic signed [DW-1:0] pa;
    logic signed [DW-1:0] qa;
    logic                 par;
    logic                 wrong_side;
    logic                 bad;
    geo_t                 geo_next;
    lane_t [LANES-1:0]    lanes_next;

    always_comb
    begin
        dx = DW'(seg.end_x) - DW'(seg.start_x);
        dy = DW'(seg.end_y) - DW'(seg.start_y);
        p[0] = -dx;
        q[0] = DW'(seg.start_x) - DW'($signed(win_x_min));
        p[1] = dx;
        q[1] = DW'($signed(win_x_max)) - DW'(seg.start_x);
        p[2] = -dy;
        q[2] = DW'(seg.start_y) - DW'($signed(win_y_min));
        p[3] = dy;
        q[3] = DW'($signed(win_y_max)) - DW'(seg.start_y);
        bad = 1'b0;
        for (int k = 0; k < LANES; k++)
        begin
            pa = p[k][DW-1] ? -p[k] : p[k];
            qa = q[k][DW-1] ? -q[k] : q[k];
            par = (p[k] == '0);
            wrong_side = (q[k] != '0) && (q[k][DW-1] != p[k][DW-1]);
            // parallel outside, or exiting before the start point
            if ((par && q[k][DW-1]) || (!par && wrong_side && !p[k][DW-1]))
                bad = 1'b1;
            lanes_next[k].active = !par && !wrong_side;
            lanes_next[k].enter  = p[k][DW-1];
            lanes_next[k].pm     = pa[COORD_BITS-1:0];
            lanes_next[k].big    = qa[COORD_BITS-1:0] > pa[COORD_BITS-1:0];
            // integer quotient bit is settled here, only set when |q| equals |p|
            if (qa[COORD_BITS-1:0] == pa[COORD_BITS-1:0])
            begin
                lanes_next[k].rem = '0;
                lanes_next[k].quo = QW'(1);
            end
            else
            begin
                lanes_next[k].rem = lanes_next[k].big ? '0 : qa[COORD_BITS-1:0];
                lanes_next[k].quo = '0;
            end
        end
        geo_next.x1  = seg.start_x;
        geo_next.y1  = seg.start_y;
        geo_next.dx  = dx;
        geo_next.dy  = dy;
        geo_next.bad = bad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg   <= geo_next;
            lanes_reg <= lanes_next;
        end
    end

endmodule

@@ rtl/lsbc_div.sv @@
// three-stage pipelined restoring divider for one edge ratio
module lsbc_div (
    input  logic            clk,
    input  logic [2:0]      en,
    input  lsbc_pkg::lane_t lane_in,
    output lsbc_pkg::lane_t lane_reg
);
    import lsbc_pkg::*;

    lane_t                 a_next;
    lane_t                 a_reg;
    lane_t                 b_next;
    lane_t                 b_reg;
    lane_t                 c_next;
    logic [COORD_BITS:0]   st_a;
    logic [COORD_BITS:0]   st_b;
    logic [COORD_BITS:0]   st_c;

    always_comb
    begin
        a_next = lane_in;
        for (int i = 0; i < DIV_A; i++)
        begin
            st_a       = div_step(a_next.rem, a_next.pm);
            a_next.rem = st_a[COORD_BITS-1:0];
            a_next.quo = {a_next.quo[QW-2:0], st_a[COORD_BITS]};
        end
    end

    always_comb
    begin
        b_next = a_reg;
        for (int i = 0; i < DIV_A; i++)
        begin
            st_b       = div_step(b_next.rem, b_next.pm);
            b_next.rem = st_b[COORD_BITS-1:0];
            b_next.quo = {b_next.quo[QW-2:0], st_b[COORD_BITS]};
        end
    end

    always_comb
    begin
        c_next = b_reg;
        for (int i = 0; i < DIV_C; i++)
        begin
            st_c       = div_step(c_next.rem, c_next.pm);
            c_next.rem = st_c[COORD_BITS-1:0];
            c_next.quo = {c_next.quo[QW-2:0], st_c[COORD_BITS]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            a_reg <= a_next;
        if (en[1])
            b_reg <= b_next;
        if (en[2])
            lane_reg <= c_next;
    end

endmodule

@@ rtl/lsbc_interp.sv @@
// parameter selection, endpoint multiply and rounding stages
module lsbc_interp (
    input  logic                                  clk,
    input  logic [2:0]                            en,
    input  lsbc_pkg::geo_t                        geo,
    input  lsbc_pkg::lane_t [lsbc_pkg::LANES-1:0] lanes,
    output lsbc_pkg::clip_t                       clip_reg
);
    import lsbc_pkg::*;

    sel_t                  sel_next;
    sel_t                  sel_reg;
    mul_t                  mul_next;
    mul_t                  mul_reg;
    clip_t                 clip_next;
    logic [TW-1:0]         r;
    logic signed [PW-1:0]  sx_in;
    logic signed [PW-1:0]  sy_in;
    logic signed [PW-1:0]  sx_out;
    logic signed [PW-1:0]  sy_out;

    always_comb
    begin
        sel_next.geo   = geo;
        sel_next.t_in  = '0;
        sel_next.t_out = T_ONE;
        for (int k = 0; k < LANES; k++)
        begin
            // round half up from the trailing quotient bit, clamp above 1.0
            r = lanes[k].big ? T_OVER
                             : lanes[k].quo[QW-1:1] + TW'(lanes[k].quo[0]);
            if (lanes[k].active)
            begin
                if (lanes[k].enter)
                begin
                    if (r > sel_next.t_in)
                        sel_next.t_in = r;
                end
                else if (r < sel_next.t_out)
                    sel_next.t_out = r;
            end
        end
        sel_next.ok = !geo.bad && (sel_next.t_in <= sel_next.t_out);
    end

    always_comb
    begin
        mul_next.x1     = sel_reg.geo.x1;
        mul_next.y1     = sel_reg.geo.y1;
        mul_next.ok     = sel_reg.ok;
        mul_next.mx_in  = PW'(sel_reg.geo.dx) * PW'($signed({1'b0, sel_reg.t_in}));
        mul_next.my_in  = PW'(sel_reg.geo.dy) * PW'($signed({1'b0, sel_reg.t_in}));
        mul_next.mx_out = PW'(sel_reg.geo.dx) * PW'($signed({1'b0, sel_reg.t_out}));
        mul_next.my_out = PW'(sel_reg.geo.dy) * PW'($signed({1'b0, sel_reg.t_out}));
    end

    always_comb
    begin
        // arithmetic shift floors both signs, giving ties toward +infinity
        sx_in  = PW'(mul_reg.x1) + ((mul_reg.mx_in + HALF) >>> FRAC_BITS);
        sy_in  = PW'(mul_reg.y1) + ((mul_reg.my_in + HALF) >>> FRAC_BITS);
        sx_out = PW'(mul_reg.x1) + ((mul_reg.mx_out + HALF) >>> FRAC_BITS);
        sy_out = PW'(mul_reg.y1) + ((mul_reg.my_out + HALF) >>> FRAC_BITS);
        if (mul_reg.ok)
        begin
            clip_next.clip_start_x = sx_in[COORD_BITS-1:0];
            clip_next.clip_start_y = sy_in[COORD_BITS-1:0];
            clip_next.clip_end_x   = sx_out[COORD_BITS-1:0];
            clip_next.clip_end_y   = sy_out[COORD_BITS-1:0];
            clip_next.visible      = 1'b1;
        end
        else
            clip_next = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            sel_reg <= sel_next;
        if (en[1])
            mul_reg <= mul_next;
        if (en[2])
            clip_reg <= clip_next;
    end

endmodule

@@ sim/line_segment_window_clipper_tb.sv @@
// testbench of the line segment window clipper: directed and random segments checked in order
`timescale 1ns / 1ps

module line_segment_window_clipper_tb;

    import lsbc_pkg::*;

    localparam int  CYCLE_LIMIT   = 300000;
    localparam int  DRAIN_CYCLES  = STAGES + 4;
    localparam int  LONG_HOLD     = 80;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = REG_Y_MAX + CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = {CFG_IDX_BITS{1'b1}};

    logic                    clk;
    logic                    rst_n;
    logic                    seg_valid;
    logic                    seg_ready;
    seg_t                    seg;
    logic                    clip_valid;
    logic                    clip_ready;
    clip_t                   clip;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [COORD_BITS-1:0]   cfg_data;

    // window as the block should hold it
    logic signed [COORD_BITS-1:0] wx_min, wx_max, wy_min, wy_max;

    clip_t expected_clips[$];
    int    errors;
    int    cycles;
    int    segs_sent;
    int    clips_seen;
    int    rejects_seen;
    bit    idle_on;
    int    hold_request;

    line_segment_window_clipper i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_valid  (seg_valid),
        .seg_ready  (seg_ready),
        .seg        (seg),
        .clip_valid (clip_valid),
        .clip_ready (clip_ready),
        .clip       (clip),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [COORD_BITS-1:0] point_on(longint s, longint d, longint t);
        longint prod;
        prod = d * t + (longint'(1) << (FRAC_BITS - 1));
        // arithmetic shift floors, which gives ties toward +infinity
        return COORD_BITS'(s + (prod >>> FRAC_BITS));
    endfunction

    function automatic clip_t clip_predict(seg_t s);
        longint x1, y1, dx, dy, pm, qm, r, t_in, t_out;
        longint pv[4];
        longint qv[4];
        bit     ok;
        clip_t  c;
        x1 = s.start_x;
        y1 = s.start_y;
        dx = longint'(s.end_x) - x1;
        dy = longint'(s.end_y) - y1;
        pv[0] = -dx; qv[0] = x1 - wx_min;
        pv[1] = dx;  qv[1] = wx_max - x1;
        pv[2] = -dy; qv[2] = y1 - wy_min;
        pv[3] = dy;  qv[3] = wy_max - y1;
        t_in  = 0;
        t_out = longint'(1) << FRAC_BITS;
        ok    = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (pv[k] == 0) begin
                if (qv[k] < 0)
                    ok = 1'b0;
            end else if (qv[k] != 0 && ((qv[k] < 0) != (pv[k] < 0))) begin
                // negative ratio only matters on an exiting edge
                if (pv[k] > 0)
                    ok = 1'b0;
            end else begin
                pm = pv[k] < 0 ? -pv[k] : pv[k];
                qm = qv[k] < 0 ? -qv[k] : qv[k];
                r  = ((qm << (FRAC_BITS + 1)) + pm) / (2 * pm);
                if (pv[k] < 0) begin
                    if (r > t_in)
                        t_in = r;
                end else if (r < t_out) begin
                    t_out = r;
                end
            end
        end
        if (t_in > t_out)
            ok = 1'b0;
        c = '0;
        if (ok) begin
            c.clip_start_x = point_on(x1, dx, t_in);
            c.clip_start_y = point_on(y1, dy, t_in);
            c.clip_end_x   = point_on(x1, dx, t_out);
            c.clip_end_y   = point_on(y1, dy, t_out);
            c.visible      = 1'b1;
        end
        return c;
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && clip_valid && clip_ready) begin
            clip_t want;
            clips_seen++;
            if (expected_clips.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual %h", $time, clip);
            end else begin
                want = expected_clips.pop_front();
                if (!want.visible)
                    rejects_seen++;
                check_field("clip_start_x", want.clip_start_x, clip.clip_start_x);
                check_field("clip_start_y", want.clip_start_y, clip.clip_start_y);
                check_field("clip_end_x", want.clip_end_x, clip.clip_end_x);
                check_field("clip_end_y", want.clip_end_y, clip.clip_end_y);
                check_field("visible", want.visible, clip.visible);
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                clip_ready <= 1'b0;
                for (n = 0; n < hold_request; n++)
                    @(negedge clk);
                hold_request = 0;
                clip_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                clip_ready <= 1'b0;
                n = $urandom_range(1, 5);
                repeat (n) @(negedge clk);
                clip_ready <= 1'b1;
            end else begin
                clip_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // entered and left at a falling edge; valid stays high for back to back requests
    task automatic send_segment(seg_t s);
        int n;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            seg_valid <= 1'b0;
            n = $urandom_range(1, 5);
            repeat (n) @(negedge clk);
        end
        seg       <= s;
        seg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!seg_ready);
        expected_clips = {expected_clips, clip_predict(s)};
        segs_sent++;
        @(negedge clk);
    endtask

    task automatic send_xy(int x1, int y1, int x2, int y2);
        seg_t s;
        s.start_x = COORD_BITS'(x1);
        s.start_y = COORD_BITS'(y1);
        s.end_x   = COORD_BITS'(x2);
        s.end_y   = COORD_BITS'(y2);
        send_segment(s);
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        while (expected_clips.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data  <= COORD_BITS'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_X_MIN: wx_min = COORD_BITS'(value);
            REG_X_MAX: wx_max = COORD_BITS'(value);
            REG_Y_MIN: wy_min = COORD_BITS'(value);
            REG_Y_MAX: wy_max = COORD_BITS'(value);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_window(int x0, int x1, int y0, int y1);
        drain();
        write_reg(REG_X_MIN, x0);
        write_reg(REG_X_MAX, x1);
        write_reg(REG_Y_MIN, y0);
        write_reg(REG_Y_MAX, y1);
    endtask

    task automatic test_reset_window();
        send_xy(100, 100, 200, 300);
        send_xy(-50, 10, 50, 10);
        send_xy(-32768, -32768, 32767, 32767);
    endtask

    task automatic test_directed_cases();
        set_window(-100, 100, -50, 50);
        send_xy(-10, -10, 10, 10);          // fully inside
        send_xy(-300, 0, 300, 0);           // crosses both x boundaries
        send_xy(0, -200, 0, 200);           // vertical through window
        send_xy(-200, 60, 200, 60);         // parallel above window
        send_xy(150, -300, 150, 300);       // parallel right of window
        send_xy(5, 5, 5, 5);                // point inside
        send_xy(500, 5, 500, 5);            // point outside
        send_xy(-300, 30, -30, 300);        // misses corner: empty interval
        send_xy(200, 0, 300, 0);            // heading away past exit edge
        send_xy(100, 50, -100, -50);        // on the corners
        send_xy(-32768, 32767, 32767, -32768);
        send_xy(32767, 0, -32768, 1);
        send_xy(-101, -51, 101, 51);
    endtask

    task automatic test_window_extremes();
        set_window(-32768, 32767, -32768, 32767);
        send_xy(-32768, -32768, 32767, 32767);
        send_xy(32767, -32768, -32768, 32767);
        set_window(100, -100, 0, 10);       // inverted x bounds
        send_xy(0, 5, 0, 5);
        send_xy(-300, 5, 300, 5);
        set_window(7, 7, -3, -3);           // single pixel window
        send_xy(7, -3, 7, -3);
        send_xy(0, -3, 20, -3);
        drain();
        write_reg(REG_SPARE_LO, 1234);      // unused index, no effect
        write_reg(REG_SPARE_HI, -1234);
        send_xy(-10, -3, 30, -3);
    endtask

    function automatic int near_coord(int lo, int hi);
        int v;
        v = $urandom_range(0, hi - lo + 400) + lo - 200;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    task automatic random_window();
        int a, b, c, d;
        a = int'($urandom_range(0, 65535)) - 32768;
        b = int'($urandom_range(0, 65535)) - 32768;
        c = int'($urandom_range(0, 65535)) - 32768;
        d = int'($urandom_range(0, 65535)) - 32768;
        if ($urandom_range(0, 3) != 0) begin
            // ordered window of modest size
            a = $urandom_range(0, 2000) - 1000;
            b = a + $urandom_range(0, 1500);
            c = $urandom_range(0, 2000) - 1000;
            d = c + $urandom_range(0, 1500);
        end
        set_window(a, b, c, d);
    endtask

    task automatic test_random_segments(int phases, int per_phase);
        seg_t s;
        for (int ph = 0; ph < phases; ph++) begin
            random_window();
            for (int i = 0; i < per_phase; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    s = seg_t'({$urandom, $urandom});
                end else begin
                    s.start_x = COORD_BITS'(near_coord(wx_min < wx_max ? wx_min : wx_max,
                                                       wx_min < wx_max ? wx_max : wx_min));
                    s.start_y = COORD_BITS'(near_coord(wy_min < wy_max ? wy_min : wy_max,
                                                       wy_min < wy_max ? wy_max : wy_min));
                    s.end_x   = COORD_BITS'(near_coord(wx_min < wx_max ? wx_min : wx_max,
                                                       wx_min < wx_max ? wx_max : wx_min));
                    s.end_y   = COORD_BITS'(near_coord(wy_min < wy_max ? wy_min : wy_max,
                                                       wy_min < wy_max ? wy_max : wy_min));
                    // axis-parallel and point segments
                    if ($urandom_range(0, 7) == 0)
                        s.end_x = s.start_x;
                    if ($urandom_range(0, 7) == 0)
                        s.end_y = s.start_y;
                end
                send_segment(s);
            end
        end
    endtask

    task automatic test_backpressure();
        set_window(-500, 500, -500, 500);
        hold_request = LONG_HOLD;
        for (int i = 0; i < 40; i++)
            send_xy(near_coord(-500, 500), near_coord(-500, 500),
                    near_coord(-500, 500), near_coord(-500, 500));
    endtask

    initial begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        seg_valid    = 1'b0;
        seg          = '0;
        clip_ready   = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        errors       = 0;
        cycles       = 0;
        segs_sent    = 0;
        clips_seen   = 0;
        rejects_seen = 0;
        idle_on      = 1'b1;
        hold_request = 0;
        wx_min = WIN_MIN_RESET;
        wx_max = WIN_MAX_RESET;
        wy_min = WIN_MIN_RESET;
        wy_max = WIN_MAX_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_window();
        test_directed_cases();
        test_window_extremes();
        test_backpressure();
        test_random_segments(12, 130);
        idle_on = 1'b0;
        test_random_segments(3, 100);
        drain();

        $display("%0d segments sent, %0d results checked, %0d of them rejected",
                 segs_sent, clips_seen, rejects_seen);
        $display("windows covered: reset, random, full range, inverted, single pixel");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lsbc_pkg.sv
rtl/lsbc_edge.sv
rtl/lsbc_div.sv
rtl/lsbc_interp.sv
rtl/line_segment_window_clipper.sv
sim/line_segment_window_clipper_tb.sv
